// ===== rtl/core/matrix_determinant_top_assert.svh =====
// Assertion macros used by the determinant RTL.
`ifndef MATRIX_DETERMINANT_TOP_ASSERT_SVH
`define MATRIX_DETERMINANT_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MDET_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MDET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mdet_pkg.sv =====
`timescale 1ns / 1ps

package mdet_pkg;

    // Width of the matrix order register.
    localparam int ORDER_W = 4;
    // Width of the determinant result.
    localparam int DET_W = 64;
    // Matrix order after reset.
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd3;
    // Half of the determinant width, the operand width of the shared multiplier.
    localparam int HALF_W = DET_W / 2;

endpackage

// ===== rtl/core/mdet_ram.sv =====
`timescale 1ns / 1ps

module mdet_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Simple dual-port array with a registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/matrix_determinant_top.sv =====
`timescale 1ns / 1ps
// Channel     | Direction | Signals                          | Transaction
// ------------+-----------+----------------------------------+-----------------------------
// input       | in        | in_valid, in_stall, element_value | in_valid & !in_stall
// result      | out       | out_valid, out_stall, determinant | out_valid & !out_stall
// config      | in        | matrix_order_we, matrix_order     | matrix_order_we
//
// Loading accepts one element per cycle; in_stall is low while the block waits for elements.
// After the last element, a sweep visits all 2^n - 1 column subsets, scanning the columns of each
// and making three passes of the shared 32x32 multiplier for every member column.
// Reset clears the control state and sets the order to 3; neither memory is cleared.
// A finished determinant waits in the output register while out_stall is high, and the
// next matrix may load meanwhile; its result waits until the register is free.

`include "matrix_determinant_top_assert.svh"

module matrix_determinant_top #(
    parameter int MAX_ORDER    = 8,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              matrix_order_we,
    input  logic [mdet_pkg::ORDER_W-1:0]      matrix_order,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [ELEMENT_BITS-1:0]    element_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [mdet_pkg::DET_W-1:0] determinant
);

    import mdet_pkg::*;

    // Counter and address widths derived from the largest order.
    localparam int JW     = $clog2(MAX_ORDER + 1);
    localparam int LCW    = $clog2(MAX_ORDER * MAX_ORDER + 1);
    localparam int EDEPTH = MAX_ORDER * MAX_ORDER;
    localparam int EAW    = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
    localparam int DDEPTH = 1 << MAX_ORDER;

    // The determinant is computed as D[S] over column subsets S: D[S] is the determinant of
    // the first |S| rows restricted to the columns in S. Expanding each along its last row
    // gives D[S] = sum over j in S of sign * a[|S|-1][j] * D[S without j], with D[empty] = 1.
    // Walking S in increasing order guarantees every smaller subset is already stored.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NEXT,
        ST_SCAN,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_ACC,
        ST_WR,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [ORDER_W-1:0]      order_reg;
    logic [LCW-1:0]          load_count_reg;
    logic [MAX_ORDER-1:0]    subset_reg;
    logic [JW-1:0]           k_reg;
    logic [JW-1:0]           j_reg;
    logic                    pos_odd_reg;
    logic [DET_W-1:0]        acc_reg;
    logic [DET_W-1:0]        term_reg;
    logic [DET_W-1:0]        prod_reg;
    logic                    out_valid_reg;
    logic [DET_W-1:0]        det_reg;

    logic [JW-1:0]           n_eff;
    logic [LCW-1:0]          total;
    logic                    load_last;
    logic [MAX_ORDER-1:0]    full_mask;
    logic [MAX_ORDER-1:0]    j_onehot;
    logic                    j_member;
    logic [JW-1:0]           subset_count;
    logic [LCW-1:0]          elem_addr_wide;
    logic                    in_accept;
    logic                    rd_en;
    logic [ELEMENT_BITS-1:0] elem_rdata;
    logic [DET_W-1:0]        dp_rdata;
    logic [DET_W-1:0]        d_val;
    logic [DET_W-1:0]        e_val;
    logic [HALF_W-1:0]       mul_a;
    logic [HALF_W-1:0]       mul_b;
    logic                    negate;

    function automatic logic [JW-1:0] count_ones(input logic [MAX_ORDER-1:0] v);
        logic [JW-1:0] c;
        c = '0;
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            c = c + JW'(v[i]);
        end
        return c;
    endfunction

    // An order of zero acts as one; orders past the maximum saturate.
    always_comb
    begin
        if (order_reg == '0)
        begin
            n_eff = JW'(1);
        end
        else if (32'(order_reg) > MAX_ORDER)
        begin
            n_eff = JW'(MAX_ORDER);
        end
        else
        begin
            n_eff = JW'(order_reg);
        end
    end

    assign total        = LCW'(n_eff) * LCW'(n_eff);
    assign load_last    = (load_count_reg + 1'b1 == total);
    assign full_mask    = MAX_ORDER'(({{MAX_ORDER{1'b0}}, 1'b1} << n_eff) - 1'b1);
    assign j_onehot     = MAX_ORDER'({{MAX_ORDER{1'b0}}, 1'b1} << j_reg);
    assign j_member     = |(subset_reg & j_onehot);
    assign subset_count = count_ones(subset_reg);
    assign elem_addr_wide = LCW'(k_reg - 1'b1) * LCW'(n_eff) + LCW'(j_reg);

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign rd_en     = (state_reg == ST_SCAN) && (j_reg != n_eff) && j_member;

    // Row-major element store, written in load order, read during the sweep.
    mdet_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (EDEPTH)
    ) u_elem_ram (
        .clk   (clk),
        .we    (in_accept),
        .waddr (load_count_reg[EAW-1:0]),
        .wdata (element_value),
        .re    (rd_en),
        .raddr (elem_addr_wide[EAW-1:0]),
        .rdata (elem_rdata)
    );

    // Subset determinant store, indexed by the column subset mask.
    mdet_ram #(
        .WIDTH (DET_W),
        .DEPTH (DDEPTH)
    ) u_dp_ram (
        .clk   (clk),
        .we    (state_reg == ST_WR),
        .waddr (subset_reg),
        .wdata (acc_reg),
        .re    (rd_en),
        .raddr (subset_reg & ~j_onehot),
        .rdata (dp_rdata)
    );

    // The determinant of the empty subset is one.
    assign d_val = (k_reg == JW'(1)) ? DET_W'(1) : dp_rdata;
    assign e_val = DET_W'(signed'(elem_rdata));

    // Low 64 bits of d * e come from three 32x32 products: the full low product and the
    // low halves of the two cross products, both added into the upper word.
    always_comb
    begin
        case (state_reg)
            ST_M0:
            begin
                mul_a = d_val[HALF_W-1:0];
                mul_b = e_val[HALF_W-1:0];
            end
            ST_M1:
            begin
                mul_a = d_val[DET_W-1:HALF_W];
                mul_b = e_val[HALF_W-1:0];
            end
            ST_M2:
            begin
                mul_a = d_val[HALF_W-1:0];
                mul_b = e_val[DET_W-1:HALF_W];
            end
            default:
            begin
                mul_a = d_val[HALF_W-1:0];
                mul_b = e_val[HALF_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= DET_W'(mul_a) * DET_W'(mul_b);
    end

    // Cofactor sign: (-1)^((|S|-1) + position of j within S).
    assign negate = ~k_reg[0] ^ pos_odd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            order_reg      <= ORDER_RESET;
            load_count_reg <= '0;
            subset_reg     <= '0;
            k_reg          <= '0;
            j_reg          <= '0;
            pos_odd_reg    <= 1'b0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // A new result takes the output register when it is empty or being drained.
            if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && load_last)
                    begin
                        subset_reg <= MAX_ORDER'(1);
                        state_reg  <= ST_NEXT;
                    end
                end
                ST_NEXT:
                begin
                    k_reg       <= subset_count;
                    j_reg       <= '0;
                    pos_odd_reg <= 1'b0;
                    acc_reg     <= '0;
                    state_reg   <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (j_reg == n_eff)
                    begin
                        state_reg <= ST_WR;
                    end
                    else if (j_member)
                    begin
                        state_reg <= ST_M0;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_M0:
                begin
                    state_reg <= ST_M1;
                end
                ST_M1:
                begin
                    term_reg  <= prod_reg;
                    state_reg <= ST_M2;
                end
                ST_M2:
                begin
                    term_reg[DET_W-1:HALF_W] <= term_reg[DET_W-1:HALF_W] + prod_reg[HALF_W-1:0];
                    state_reg <= ST_M3;
                end
                ST_M3:
                begin
                    term_reg[DET_W-1:HALF_W] <= term_reg[DET_W-1:HALF_W] + prod_reg[HALF_W-1:0];
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    acc_reg     <= negate ? (acc_reg - term_reg) : (acc_reg + term_reg);
                    j_reg       <= j_reg + 1'b1;
                    pos_odd_reg <= ~pos_odd_reg;
                    state_reg   <= ST_SCAN;
                end
                ST_WR:
                begin
                    if (subset_reg == full_mask)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        subset_reg <= subset_reg + 1'b1;
                        state_reg  <= ST_NEXT;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        det_reg   <= acc_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // A write to the order always restarts loading.
            if (matrix_order_we)
            begin
                order_reg      <= matrix_order;
                load_count_reg <= '0;
            end
            else if (in_accept)
            begin
                load_count_reg <= load_last ? '0 : (load_count_reg + 1'b1);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign determinant = det_reg;

    `MDET_ASSERT_NEXT(a_valid_from_done, !out_valid_reg && state_reg != ST_DONE,
        !out_valid_reg, "result valid raised outside the done state")
    `MDET_ASSERT_NOW(a_k_in_range, state_reg == ST_SCAN, k_reg <= n_eff && k_reg != '0,
        "subset size out of range during sweep")
    `MDET_ASSERT_NOW(a_mul_on_member, state_reg == ST_M0, j_member && j_reg < n_eff,
        "product started for a column outside the subset")
    `MDET_ASSERT_NOW(a_load_in_range, state_reg == ST_IDLE, load_count_reg < total,
        "load count past the matrix size")

endmodule
